// ===== rtl/dtc_pkg.sv =====
// Shared types, constants and helper functions for the Duffing trajectory check.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dtc_pkg;

    localparam int STEPS        = 100;
    localparam int STEP_W       = 8;
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_IW    = 5;
    localparam int MUL_OPS      = 6;

    typedef logic signed [39:0] q832_t;
    typedef logic signed [33:0] cord_t;

    localparam q832_t DT_Q32    = 40'sd42949673;
    localparam q832_t DAMP_Q32  = 40'sd429496730;
    localparam q832_t FORCE_Q32 = 40'sd1288490189;
    localparam q832_t LIM40     = 40'sd549755813887;
    localparam logic signed [43:0] LIM44 = 44'sd549755813887;

    localparam cord_t TIME_TURN_K  = 34'sd1749927105;
    localparam cord_t PHASE_TURN_K = 34'sd2670177;
    localparam cord_t CORDIC_GAIN  = 34'sd652032874;

    localparam logic [30:0] DRIFT_MAX       = 31'h7FFF_FFFF;
    localparam logic [30:0] DRIFT_LIMIT_RST = 31'd6554;

    typedef enum logic [2:0] {
        MUL_F_C  = 3'd0,
        MUL_D_V  = 3'd1,
        MUL_P_P  = 3'd2,
        MUL_T_P  = 3'd3,
        MUL_V_DT = 3'd4,
        MUL_A_DT = 3'd5
    } mul_sel_t;

    typedef enum logic [2:0] {
        AUX_WK  = 3'd0,
        AUX_PH  = 3'd1,
        AUX_AMP = 3'd2,
        AUX_MX  = 3'd3,
        AUX_MV  = 3'd4
    } aux_sel_t;

    typedef enum logic {
        COS_STEP = 1'b0,
        COS_PEER = 1'b1
    } cos_src_t;

    typedef struct packed {
        logic     load;
        logic     wk_load;
        logic     aux_en;
        aux_sel_t aux_sel;
        logic     cos_start;
        cos_src_t cos_src;
        logic     acc_init;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     ang_adv;
        logic     diff_load;
        logic     sq_first;
        logic     sq_add;
        logic     root_start;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic cos_done;
        logic mul_done;
        logic root_done;
    } sts_t;

    // Arctangent of 2^-i in Q0.32 turns.
    function automatic cord_t atan_turn(input logic [CORDIC_IW-1:0] i);
        cord_t r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            5'd24: r = 34'sd41;
            5'd25: r = 34'sd20;
            5'd26: r = 34'sd10;
            5'd27: r = 34'sd5;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // Symmetric saturation to the Q8.32 range.
    function automatic q832_t sat40(input logic signed [43:0] v);
        q832_t r;
        if (v > LIM44)
            r = LIM40;
        else if (v < -LIM44)
            r = -LIM40;
        else
            r = v[39:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dtc_cordic.sv =====
// Iterative rotation CORDIC: cosine of an angle in turns, one iteration per cycle.
// Depends on dtc_pkg.
`default_nettype none

module dtc_cordic (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [31:0]   angle,
    output logic               done,
    output dtc_pkg::cord_t     cos_out
);
    import dtc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CORDIC_IW-1:0] iter_reg, iter_next;
    cord_t                x_reg, x_next;
    cord_t                y_reg, y_next;
    cord_t                z_reg, z_next;
    logic                 flip_reg, flip_next;

    logic [31:0] quarter_sum;
    logic [31:0] folded;
    cord_t       sh_x, sh_y, at;

    always_comb
    begin
        quarter_sum = angle + 32'h4000_0000;
        folded      = quarter_sum[31] ? (angle + 32'h8000_0000) : angle;
        sh_x        = x_reg >>> iter_reg;
        sh_y        = y_reg >>> iter_reg;
        at          = atan_turn(iter_reg);

        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;

        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = {{2{folded[31]}}, folded};
            flip_next = quarter_sum[31];
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - sh_y;
                y_next = y_reg + sh_x;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + sh_y;
                y_next = y_reg - sh_x;
                z_next = z_reg + at;
            end
            if (iter_reg == CORDIC_IW'(CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                iter_next = iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;

endmodule

`default_nettype wire

// ===== rtl/dtc_mulq.sv =====
// Two-stage Q8.32 multiplier: magnitude product truncated, saturated, signed.
// Partial products are registered in the first stage. Depends on dtc_pkg.
`default_nettype none

module dtc_mulq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  dtc_pkg::q832_t     a,
    input  dtc_pkg::q832_t     b,
    output logic               done,
    output dtc_pkg::q832_t     result
);
    import dtc_pkg::*;

    logic        v1_reg, done_reg;
    logic        neg_reg;
    logic [63:0] ll_reg;
    logic [39:0] hl_reg, lh_reg;
    logic [15:0] hh_reg;
    q832_t       res_reg;

    logic [39:0] ua, ub;
    logic [48:0] r_sum;
    logic [39:0] mag;

    always_comb
    begin
        ua    = a[39] ? 40'(-a) : 40'(a);
        ub    = b[39] ? 40'(-b) : 40'(b);
        r_sum = {1'b0, hh_reg, 32'd0} + 49'(hl_reg) + 49'(lh_reg) + 49'(ll_reg[63:32]);
        mag   = (r_sum > 49'(LIM40)) ? 40'(LIM40) : r_sum[39:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[39] ^ b[39];
            ll_reg  <= 64'(ua[31:0]) * 64'(ub[31:0]);
            hl_reg  <= 40'(ua[39:32]) * 40'(ub[31:0]);
            lh_reg  <= 40'(ua[31:0]) * 40'(ub[39:32]);
            hh_reg  <= 16'(ua[39:32]) * 16'(ub[39:32]);
        end
        if (v1_reg)
        begin
            res_reg <= neg_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== rtl/dtc_isqrt.sv =====
// Bit-serial floor square root of a 64-bit value, two radicand bits per cycle.
// Imports dtc_pkg, though it uses none of its items.
`default_nettype none

module dtc_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    import dtc_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] n_reg, n_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    always_comb
    begin
        trial     = res_reg + bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            n_next    = radicand;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 64'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

`default_nettype wire

// ===== rtl/dtc_datapath.sv =====
// Datapath: integration state, angle accumulator, shared multipliers, CORDIC,
// square root and the result register. Depends on dtc_pkg, dtc_cordic,
// dtc_mulq and dtc_isqrt.
`default_nettype none

module dtc_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  dtc_pkg::cmd_t           cmd,
    output dtc_pkg::sts_t           sts,
    input  wire logic signed [31:0] forcing_freq,
    input  wire logic signed [31:0] peer_amplitude,
    input  wire logic signed [31:0] peer_phase,
    input  wire logic signed [31:0] peer_velocity,
    input  wire logic [30:0]        drift_limit,
    output logic [30:0]             drift,
    output logic                    accepted
);
    import dtc_pkg::*;

    logic signed [31:0] w_reg, amp_reg, ph_reg, pv_reg;
    logic [55:0]        wk_reg, ang_reg;
    logic signed [63:0] prod_reg;
    q832_t              p_reg, v_reg, tmp_reg, pd_reg;
    logic signed [42:0] acc_reg;
    logic [30:0]        mx_reg, mv_reg;
    logic               big_reg;
    logic [62:0]        sum_reg;
    logic [30:0]        drift_reg;
    logic               accepted_reg;

    cord_t              aux_a, aux_b;
    logic signed [67:0] aux_prod;
    logic [31:0]        cos_angle;
    cord_t              cos_val;
    q832_t              c40, acc_sat, mul_a, mul_b, mres;
    logic               cos_done, mul_done, root_done;
    logic [31:0]        root;
    logic signed [63:0] px, dx, dv, ax, av;
    logic [47:0]        mx, mv;
    logic [30:0]        drift_new;

    always_comb
    begin
        case (cmd.aux_sel)
            AUX_WK:
            begin
                aux_a = 34'(w_reg);
                aux_b = TIME_TURN_K;
            end
            AUX_PH:
            begin
                aux_a = 34'(ph_reg);
                aux_b = PHASE_TURN_K;
            end
            AUX_AMP:
            begin
                aux_a = 34'(amp_reg);
                aux_b = cos_val;
            end
            AUX_MX:
            begin
                aux_a = $signed({3'b000, mx_reg});
                aux_b = $signed({3'b000, mx_reg});
            end
            AUX_MV:
            begin
                aux_a = $signed({3'b000, mv_reg});
                aux_b = $signed({3'b000, mv_reg});
            end
            default:
            begin
                aux_a = '0;
                aux_b = '0;
            end
        endcase
        aux_prod = aux_a * aux_b;

        cos_angle = (cmd.cos_src == COS_STEP) ? ang_reg[55:24] : prod_reg[39:8];

        c40     = {{4{cos_val[33]}}, cos_val, 2'b00};
        acc_sat = sat40(44'(acc_reg));

        case (cmd.mul_sel)
            MUL_F_C:
            begin
                mul_a = FORCE_Q32;
                mul_b = c40;
            end
            MUL_D_V:
            begin
                mul_a = DAMP_Q32;
                mul_b = v_reg;
            end
            MUL_P_P:
            begin
                mul_a = p_reg;
                mul_b = p_reg;
            end
            MUL_T_P:
            begin
                mul_a = tmp_reg;
                mul_b = p_reg;
            end
            MUL_V_DT:
            begin
                mul_a = v_reg;
                mul_b = DT_Q32;
            end
            MUL_A_DT:
            begin
                mul_a = acc_sat;
                mul_b = DT_Q32;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        // Distance terms: both components at 32 fraction bits, magnitudes cut to Q32.16.
        px = prod_reg >>> 14;
        dx = 64'(p_reg) - px;
        dv = 64'(v_reg) - (64'(pv_reg) <<< 16);
        ax = dx[63] ? -dx : dx;
        av = dv[63] ? -dv : dv;
        mx = ax[63:16];
        mv = av[63:16];

        drift_new = (big_reg || root[31]) ? DRIFT_MAX : root[30:0];
    end

    dtc_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.cos_start),
        .angle   (cos_angle),
        .done    (cos_done),
        .cos_out (cos_val)
    );

    dtc_mulq u_mulq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mres)
    );

    dtc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand ({1'b0, sum_reg}),
        .done     (root_done),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg   <= forcing_freq;
            amp_reg <= peer_amplitude;
            ph_reg  <= peer_phase;
            pv_reg  <= peer_velocity;
            p_reg   <= '0;
            v_reg   <= '0;
            ang_reg <= '0;
        end
        if (cmd.aux_en)
        begin
            prod_reg <= aux_prod[63:0];
        end
        if (cmd.wk_load)
        begin
            wk_reg <= prod_reg[55:0];
        end
        if (cmd.ang_adv)
        begin
            ang_reg <= ang_reg + wk_reg;
        end
        if (cmd.acc_init)
        begin
            acc_reg <= 43'(p_reg);
        end
        if (mul_done)
        begin
            case (cmd.mul_sel)
                MUL_F_C:  acc_reg <= acc_reg + 43'(mres);
                MUL_D_V:  acc_reg <= acc_reg - 43'(mres);
                MUL_P_P:  tmp_reg <= mres;
                MUL_T_P:  acc_reg <= acc_reg - 43'(mres);
                MUL_V_DT: pd_reg  <= mres;
                MUL_A_DT:
                begin
                    v_reg <= sat40(44'(v_reg) + 44'(mres));
                    p_reg <= sat40(44'(p_reg) + 44'(pd_reg));
                end
                default:  tmp_reg <= tmp_reg;
            endcase
        end
        if (cmd.diff_load)
        begin
            mx_reg  <= mx[30:0];
            mv_reg  <= mv[30:0];
            big_reg <= (|mx[47:31]) || (|mv[47:31]);
        end
        if (cmd.sq_first)
        begin
            sum_reg <= prod_reg[62:0];
        end
        if (cmd.sq_add)
        begin
            sum_reg <= sum_reg + prod_reg[62:0];
        end
        if (cmd.out_load)
        begin
            drift_reg    <= drift_new;
            accepted_reg <= (drift_new <= drift_limit);
        end
    end

    assign sts.cos_done  = cos_done;
    assign sts.mul_done  = mul_done;
    assign sts.root_done = root_done;
    assign drift         = drift_reg;
    assign accepted      = accepted_reg;

endmodule

`default_nettype wire

// ===== rtl/dtc_ctrl.sv =====
// Controller: sequences the integration steps, the final distance and the
// output handshake. Depends on dtc_pkg.
`default_nettype none

module dtc_ctrl (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output dtc_pkg::cmd_t cmd,
    input  dtc_pkg::sts_t sts
);
    import dtc_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE      = 19'h00001,
        S_WK        = 19'h00002,
        S_WKLD      = 19'h00004,
        S_COS_GO    = 19'h00008,
        S_COS_WAIT  = 19'h00010,
        S_MUL_GO    = 19'h00020,
        S_MUL_WAIT  = 19'h00040,
        S_STEP_END  = 19'h00080,
        S_PH        = 19'h00100,
        S_PCOS_GO   = 19'h00200,
        S_PCOS_WAIT = 19'h00400,
        S_AMP       = 19'h00800,
        S_DIFF      = 19'h01000,
        S_SQX       = 19'h02000,
        S_SQV       = 19'h04000,
        S_SUM       = 19'h08000,
        S_ROOT_GO   = 19'h10000,
        S_ROOT_WAIT = 19'h20000,
        S_DONE      = 19'h40000
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.mul_sel = mul_sel_t'(op_reg);
        cmd.aux_sel = AUX_WK;
        cmd.cos_src = COS_STEP;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WK;
                end
            end
            S_WK:
            begin
                cmd.aux_en  = 1'b1;
                cmd.aux_sel = AUX_WK;
                state_next  = S_WKLD;
            end
            S_WKLD:
            begin
                cmd.wk_load = 1'b1;
                step_next   = '0;
                state_next  = S_COS_GO;
            end
            S_COS_GO:
            begin
                cmd.cos_start = 1'b1;
                cmd.cos_src   = COS_STEP;
                cmd.acc_init  = 1'b1;
                state_next    = S_COS_WAIT;
            end
            S_COS_WAIT:
            begin
                if (sts.cos_done)
                begin
                    op_next    = '0;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (sts.mul_done)
                begin
                    if (op_reg == 3'(MUL_OPS - 1))
                    begin
                        state_next = S_STEP_END;
                    end
                    else
                    begin
                        op_next    = op_reg + 1'b1;
                        state_next = S_MUL_GO;
                    end
                end
            end
            S_STEP_END:
            begin
                cmd.ang_adv = 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = S_PH;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_COS_GO;
                end
            end
            S_PH:
            begin
                cmd.aux_en  = 1'b1;
                cmd.aux_sel = AUX_PH;
                state_next  = S_PCOS_GO;
            end
            S_PCOS_GO:
            begin
                cmd.cos_start = 1'b1;
                cmd.cos_src   = COS_PEER;
                state_next    = S_PCOS_WAIT;
            end
            S_PCOS_WAIT:
            begin
                if (sts.cos_done)
                begin
                    state_next = S_AMP;
                end
            end
            S_AMP:
            begin
                cmd.aux_en  = 1'b1;
                cmd.aux_sel = AUX_AMP;
                state_next  = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = S_SQX;
            end
            S_SQX:
            begin
                cmd.aux_en  = 1'b1;
                cmd.aux_sel = AUX_MX;
                state_next  = S_SQV;
            end
            S_SQV:
            begin
                cmd.sq_first = 1'b1;
                cmd.aux_en   = 1'b1;
                cmd.aux_sel  = AUX_MV;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                cmd.sq_add = 1'b1;
                state_next = S_ROOT_GO;
            end
            S_ROOT_GO:
            begin
                cmd.root_start = 1'b1;
                state_next     = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (sts.root_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // The result register frees up in the same cycle its transaction completes.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mul_done |-> state_reg == S_MUL_WAIT)
        else $error("multiplier finished outside its wait state");
    a_cos_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.cos_done |-> (state_reg == S_COS_WAIT || state_reg == S_PCOS_WAIT))
        else $error("cosine finished outside its wait state");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == S_WK)
        else $error("accepted transaction did not start a run");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < STEP_W'(STEPS))
        else $error("step counter out of range");
    a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
        op_reg < 3'(MUL_OPS))
        else $error("multiply operation index out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/duffing_trajectory_check_unit.sv =====
// Duffing trajectory check, top level: stream ports, APB register and the two halves.
// Each of the 100 integration steps is dominated by the 30-iteration CORDIC cosine.
// Throughput: one transaction per run; the next is accepted once a run has handed
// its result to the output register. Reset (rst_n, asynchronous, active low) idles
// the controller, empties the output register and sets drift_limit to 6554.
`default_nettype none

module duffing_trajectory_check_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // s_tdata: forcing_freq [31:0], peer_amplitude [63:32], peer_phase [95:64],
    // peer_velocity [127:96]
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,
    // m_tdata: drift [30:0], accepted [31]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import dtc_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [30:0] limit_reg;
    logic [30:0] drift;
    logic        accepted;
    logic        reg_hit;

    assign reg_hit = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {1'b0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= DRIFT_LIMIT_RST;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            limit_reg <= pwdata[30:0];
        end
    end

    dtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    dtc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .forcing_freq   (s_tdata[31:0]),
        .peer_amplitude (s_tdata[63:32]),
        .peer_phase     (s_tdata[95:64]),
        .peer_velocity  (s_tdata[127:96]),
        .drift_limit    (limit_reg),
        .drift          (drift),
        .accepted       (accepted)
    );

    assign m_tdata = {accepted, drift};

endmodule

`default_nettype wire

// ===== test/duffing_trajectory_check_unit_test.sv =====
// Self-checking testbench for duffing_trajectory_check_unit: an in-bench integrator
// predicts drift and the pass flag for every request. Depends on rtl/dtc_pkg.sv and the RTL.
`timescale 1ns / 1ps

module duffing_trajectory_check_unit_test;

    import dtc_pkg::*;

    localparam int  N_RANDOM    = 1500;
    localparam int  DRAIN_WAIT  = 6000;
    localparam longint MAX_CYCLES = 64'd40_000_000;
    localparam logic [2:0] ADDR_DRIFT_LIMIT = 3'd0;
    localparam logic [2:0] ADDR_UNUSED      = 3'd4;

    localparam longint ATAN_TBL [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };
    localparam longint STATE_MAX = 64'sd549755813887;

    typedef struct {
        logic [30:0] drift;
        logic        pass;
    } verdict_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    logic [30:0]  limit_model;
    verdict_t     verdict_queue[$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           passes_seen = 0;
    int           items_sent;
    longint       cycle_count = 0;
    longint       end_pos;
    longint       end_vel;

    duffing_trajectory_check_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint clamp_state(input longint v);
        if (v > STATE_MAX)
            return STATE_MAX;
        if (v < -STATE_MAX)
            return -STATE_MAX;
        return v;
    endfunction

    // Q8.32 product, magnitude truncated, then clamped.
    function automatic longint q32_mul(input longint a, input longint b);
        logic neg;
        longint unsigned ua, ub, ah, al, bh, bl, r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        ua &= 64'hFF_FFFF_FFFF;
        ub &= 64'hFF_FFFF_FFFF;
        ah = ua >> 32;
        al = ua & 64'hFFFF_FFFF;
        bh = ub >> 32;
        bl = ub & 64'hFFFF_FFFF;
        r = ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
        if (r > STATE_MAX)
            r = STATE_MAX;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Rotation CORDIC cosine of an angle in Q0.32 turns, Q2.30 result.
    function automatic longint cosine_q30(input logic [31:0] angle);
        logic   fold;
        longint x, y, z, nx;
        fold = 1'b0;
        x = 652032874;
        y = 0;
        if (((angle + 32'h4000_0000) & 32'h8000_0000) != 0)
        begin
            angle = angle + 32'h8000_0000;
            fold  = 1'b1;
        end
        z = longint'(signed'(angle));
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TBL[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TBL[i];
            end
            x = nx;
        end
        return fold ? -x : x;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Integrates the oscillator for one request; leaves the end state in end_pos/end_vel.
    task automatic integrate_trajectory(input logic signed [31:0] freq);
        longint          pos, vel, accel, cval;
        longint unsigned prod;
        pos = 0;
        vel = 0;
        for (int k = 0; k < STEPS; k++)
        begin
            prod  = longint'(freq) * longint'(k) * 64'd1749927105;
            cval  = cosine_q30(prod[55:24]) * 4;
            accel = q32_mul(1288490189, cval) - q32_mul(429496730, vel) + pos
                    - q32_mul(q32_mul(pos, pos), pos);
            accel = clamp_state(accel);
            pos   = clamp_state(pos + q32_mul(vel, 42949673));
            vel   = clamp_state(vel + q32_mul(accel, 42949673));
        end
        end_pos = pos;
        end_vel = vel;
    endtask

    function automatic verdict_t predict_verdict(input logic signed [31:0] amp,
                                                 input logic signed [31:0] phase,
                                                 input logic signed [31:0] vel_claim);
        verdict_t        v;
        longint unsigned prod, mx, mv, root;
        longint          px, dx, dv;
        prod = longint'(phase) * 64'd2670177;
        px   = (longint'(amp) * cosine_q30(prod[39:8])) >>> 14;
        dx   = end_pos - px;
        dv   = end_vel - longint'(vel_claim) * 65536;
        mx   = ((dx < 0) ? -dx : dx) >> 16;
        mv   = ((dv < 0) ? -dv : dv) >> 16;
        if (mx > 64'h7FFF_FFFF || mv > 64'h7FFF_FFFF)
            root = 64'h7FFF_FFFF;
        else
        begin
            root = floor_sqrt(mx * mx + mv * mv);
            if (root > 64'h7FFF_FFFF)
                root = 64'h7FFF_FFFF;
        end
        v.drift = root[30:0];
        v.pass  = (root[30:0] <= limit_model);
        return v;
    endfunction

    // A zero gap keeps tvalid high so that requests follow back to back.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 150);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n != 0)
            s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Sends one request and queues its expected verdict.
    task automatic send_request(input logic [31:0] freq, input logic [31:0] amp,
                                input logic [31:0] phase, input logic [31:0] vel);
        integrate_trajectory(freq);
        verdict_queue.push_back(predict_verdict(amp, phase, vel));
        idle_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= {vel, phase, amp, freq};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (verdict_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DRIFT_LIMIT)
            limit_model = value[30:0];
        @(posedge clk);
    endtask

    task automatic test_field_extremes();
        logic [31:0] ext [4];
        ext = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        for (int i = 0; i < 4; i++)
        begin
            send_request(ext[i], 32'h0, 32'h0, 32'h0);
            send_request(32'h0, ext[i], 32'h0, 32'h0);
            send_request(32'h0, 32'h0001_0000, ext[i], 32'h0);
            send_request(32'h0, 32'h0, 32'h0, ext[i]);
        end
        // Both components at their largest: the distance saturates.
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    endtask

    // A claim built from the true end state, so that the pass flag really toggles.
    task automatic send_matching_claim(input logic [31:0] freq, input int noise);
        longint amp, vel;
        integrate_trajectory(freq);
        amp = (end_pos >>> 16) + $signed($urandom_range(0, 2 * noise)) - noise;
        vel = (end_vel >>> 16) + $signed($urandom_range(0, 2 * noise)) - noise;
        send_request(freq, amp[31:0], 32'h0, vel[31:0]);
    endtask

    task automatic test_near_claims();
        send_matching_claim(32'h0001_0000, 0);
        send_matching_claim(32'h0003_2000, 0);
        send_matching_claim(32'hFFFE_0000, 100);
    endtask

    task automatic test_random_requests(input int count);
        logic [31:0] freq;
        for (int i = 0; i < count; i++)
        begin
            freq = ($urandom_range(0, 1) == 0) ? $urandom()
                   : 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            case ($urandom_range(0, 3))
                0: send_request(freq, $urandom(), $urandom(), $urandom());
                1: send_matching_claim(freq, $urandom_range(0, 8000));
                default: send_matching_claim(freq, $urandom_range(0, 200));
            endcase
        end
    endtask

    task automatic test_drift_limits();
        logic [31:0] settings [4];
        settings = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_1000, 32'h0000_2000};
        for (int i = 0; i < 4; i++)
        begin
            wait_idle();
            write_register(ADDR_DRIFT_LIMIT, settings[i]);
            // A write to an unmapped address must leave the limit alone.
            write_register(ADDR_UNUSED, $urandom());
            test_near_claims();
            test_random_requests(N_RANDOM / 8);
        end
        wait_idle();
        write_register(ADDR_DRIFT_LIMIT, 32'd6554);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tdata[31])
                passes_seen++;
            if (verdict_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: drift %0d pass %0d",
                             m_tdata[30:0], m_tdata[31]);
            end
            else
            begin
                e = verdict_queue.pop_front();
                if (m_tdata[30:0] !== e.drift || m_tdata[31] !== e.pass)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: drift exp %0d got %0d, pass exp %0d got %0d",
                                 e.drift, m_tdata[30:0], e.pass, m_tdata[31]);
                end
            end
        end
    end

    // Output backpressure: long ready stretches with short and occasional long stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b1;
        else if ($urandom_range(0, 99) < 8)
            m_tready <= ~m_tready;
        else if (!m_tready && $urandom_range(0, 99) < 3)
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        limit_model  = 31'd6554;
        items_sent   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_near_claims();
        test_drift_limits();
        test_random_requests(N_RANDOM / 2);

        wait_idle();
        $display("Sent %0d requests over five drift limits, got %0d results (%0d passing).",
                 items_sent, results_seen, passes_seen);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
